[rtl/dcu_pkg.sv]
package dcu_pkg;

  localparam int BASE_YEAR_DEF = 1800;
  localparam int MAX_YEAR_DEF  = 4095;

  localparam int OP_W   = 1;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int YP_W   = YEAR_W + 1;
  localparam int OFF_W  = 21;
  localparam int DIST_W = 20;
  localparam int WD_W   = 3;
  localparam int ST_W   = 2;
  localparam int REL_W  = 20;
  localparam int ORD_W  = 24;
  localparam int DBY_W  = 22;

  typedef enum logic [OP_W-1:0] {
    OP_SHIFT = 1'b0,
    OP_DIST  = 1'b1
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BEFORE  = 2'd2,
    ST_BEYOND  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_OA,
    S_OB,
    S_DIFF,
    S_ABS,
    S_ADD,
    S_RANGE,
    S_EST,
    S_YLO,
    S_YSEL,
    S_YCMP,
    S_REST,
    S_MON,
    S_WD,
    S_PUT
  } state_e;

  typedef struct packed {
    logic signed [ORD_W-1:0] a;
    logic signed [ORD_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  // floor(y / 100) by reciprocal, exact for y below 8192
  function automatic logic [YP_W-1:0] div100(input logic [YP_W-1:0] y);
    logic [31:0] prod;
    prod = 32'(y) * 32'd5243;
    return YP_W'(prod >> 19);
  endfunction

  function automatic logic is_leap(input logic [YP_W-1:0] y);
    logic [YP_W-1:0] q;
    logic [19:0]     q100;
    q    = div100(y);
    q100 = 20'(q) * 20'd100;
    return ((y[1:0] == 2'b00) && (y != q100[YP_W-1:0])) ||
           ((y == q100[YP_W-1:0]) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                     input logic [YP_W-1:0] y);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m,
                                                   input logic [YP_W-1:0] y);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if ((m > 4'd2) && is_leap(y)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

  // days before 1 january of year y from the proleptic epoch
  function automatic logic [DBY_W-1:0] dby_abs(input logic [YP_W-1:0] y);
    logic [YP_W-1:0]  p;
    logic [YP_W-1:0]  q;
    logic [DBY_W-1:0] n;
    p = y - YP_W'(1);
    q = div100(p);
    n = DBY_W'(p) * DBY_W'(365) + DBY_W'(p >> 2) - DBY_W'(q) + DBY_W'(q >> 2);
    return n;
  endfunction

endpackage

[rtl/dcu_if.sv]
interface dcu_req_if;
  logic                              valid;
  logic                              ready;
  logic [dcu_pkg::OP_W-1:0]          opcode;
  logic [dcu_pkg::DAY_W-1:0]         day_a;
  logic [dcu_pkg::MON_W-1:0]         month_a;
  logic [dcu_pkg::YEAR_W-1:0]        year_a;
  logic signed [dcu_pkg::OFF_W-1:0]  offset;
  logic [dcu_pkg::DAY_W-1:0]         day_b;
  logic [dcu_pkg::MON_W-1:0]         month_b;
  logic [dcu_pkg::YEAR_W-1:0]        year_b;

  modport source (
    output valid, opcode, day_a, month_a, year_a, offset, day_b, month_b, year_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, day_a, month_a, year_a, offset, day_b, month_b, year_b,
    output ready
  );
endinterface

interface dcu_res_if;
  logic                        valid;
  logic                        ready;
  logic [dcu_pkg::DAY_W-1:0]   res_day;
  logic [dcu_pkg::MON_W-1:0]   res_month;
  logic [dcu_pkg::YEAR_W-1:0]  res_year;
  logic [dcu_pkg::DIST_W-1:0]  distance;
  logic [dcu_pkg::WD_W-1:0]    weekday;
  logic [dcu_pkg::ST_W-1:0]    status;

  modport source (
    output valid, res_day, res_month, res_year, distance, weekday, status,
    input  ready
  );
  modport sink (
    input  valid, res_day, res_month, res_year, distance, weekday, status,
    output ready
  );
endinterface

[rtl/dcu_alu.sv]
module dcu_alu (
  input  dcu_pkg::alu_req_t                req_i,
  output logic signed [dcu_pkg::ORD_W-1:0] sum_o
);

  assign sum_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule

[rtl/dcu_dby.sv]
module dcu_dby #(
  parameter int BASE_YEAR = dcu_pkg::BASE_YEAR_DEF
) (
  input  logic                        clk_i,
  input  logic [dcu_pkg::YP_W-1:0]    year_i,
  output logic [dcu_pkg::REL_W-1:0]   dby_o
);

  localparam logic [dcu_pkg::DBY_W-1:0] DBY_BASE =
    dcu_pkg::dby_abs(dcu_pkg::YP_W'(BASE_YEAR));

  logic [dcu_pkg::REL_W-1:0] dby_q;
  logic [dcu_pkg::DBY_W-1:0] dby_d;

  // day count before the year, relative to 1 january of the base year
  assign dby_d = dcu_pkg::dby_abs(year_i) - DBY_BASE;

  always_ff @(posedge clk_i) begin
    dby_q <= dby_d[dcu_pkg::REL_W-1:0];
  end

  assign dby_o = dby_q;

endmodule

[rtl/calendar_date_arithmetic_unit.sv]
// channel  modport  direction  contents
// req_i    sink     in         opcode, date a, offset, date b
// res_o    source   out        result date, distance, weekday, status
//
// one request at a time; the time from acceptance to a valid result depends on the path, set
// for a shift by the year search and the month walk that share one adder with the ordinal
// sums; ready returns in the same cycle as the result turns valid.
// a finished result waits in the output register while the next request is taken.
// rst_ni clears the sequencer and the output valid flag asynchronously.
module calendar_date_arithmetic_unit #(
  parameter int BASE_YEAR = dcu_pkg::BASE_YEAR_DEF,
  parameter int MAX_YEAR  = dcu_pkg::MAX_YEAR_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dcu_req_if.sink           req_i,
  dcu_res_if.source         res_o
);

  localparam int ORD_W  = dcu_pkg::ORD_W;
  localparam int REL_W  = dcu_pkg::REL_W;
  localparam int YP_W   = dcu_pkg::YP_W;
  localparam int DAY_W  = dcu_pkg::DAY_W;
  localparam int MON_W  = dcu_pkg::MON_W;
  localparam int YEAR_W = dcu_pkg::YEAR_W;
  localparam int DIST_W = dcu_pkg::DIST_W;
  localparam int WD_W   = dcu_pkg::WD_W;
  localparam int OFF_W  = dcu_pkg::OFF_W;

  localparam int YEAR_CAP  = (MAX_YEAR < 4095) ? MAX_YEAR : 4095;
  localparam int DBY_BASE  = int'(dcu_pkg::dby_abs(YP_W'(BASE_YEAR)));
  localparam int DBY_1800  = int'(dcu_pkg::dby_abs(YP_W'(1800)));
  localparam int LIMIT_REL = int'(dcu_pkg::dby_abs(YP_W'(YEAR_CAP + 1))) - DBY_BASE;
  localparam int WD_ANCHOR = (((DBY_BASE - DBY_1800) % 7) + 7) % 7;
  localparam int WD_OFF    = (WD_ANCHOR + 2) % 7;
  localparam int DIST_MAX  = (1 << DIST_W) - 1;
  localparam int EST_K     = 2933722;
  localparam int EST_SH    = 30;
  localparam int EST_PW    = REL_W + 22;
  localparam int M7_K      = 1198373;
  localparam int M7_SH     = 23;
  localparam int M7_PW     = REL_W + 21;

  dcu_pkg::state_e state_q, state_d;

  dcu_pkg::opcode_e         op_q;
  logic [DAY_W-1:0]         da_q, db_q;
  logic [MON_W-1:0]         ma_q, mb_q;
  logic [YEAR_W-1:0]        ya_q, yb_q;
  logic signed [OFF_W-1:0]  off_q;
  logic signed [ORD_W-1:0]  acc_a_q, acc_b_q, n_q;
  logic [YP_W-1:0]          yy_q;
  logic [REL_W-1:0]         lo_q;
  logic [8:0]               rest_q;
  logic [MON_W-1:0]         mm_q;
  logic [DAY_W-1:0]         rd_q;
  logic [MON_W-1:0]         rm_q;
  logic [YEAR_W-1:0]        ry_q;
  logic [DIST_W-1:0]        dist_q;
  logic [WD_W-1:0]          wd_q;
  dcu_pkg::status_e         st_q;

  logic                     out_valid_q;
  logic [DAY_W-1:0]         out_day_q;
  logic [MON_W-1:0]         out_month_q;
  logic [YEAR_W-1:0]        out_year_q;
  logic [DIST_W-1:0]        out_dist_q;
  logic [WD_W-1:0]          out_wd_q;
  dcu_pkg::status_e         out_st_q;

  dcu_pkg::alu_req_t        alu_req;
  logic signed [ORD_W-1:0]  alu_sum;
  logic [YP_W-1:0]          year_sel;
  logic [REL_W-1:0]         dby_q;

  logic                     req_ready;
  logic                     req_take;
  logic                     out_free;
  logic                     valid_a, valid_b;
  logic [9:0]               k_a, k_b;
  logic [EST_PW-1:0]        est_prod;
  logic [YP_W-1:0]          est_year;
  logic signed [ORD_W-1:0]  wd_sel;
  logic [M7_PW-1:0]         m7_prod;
  logic [REL_W-1:0]         m7_q;
  logic [REL_W-1:0]         m7_rem;
  logic [3:0]               wd_sum;
  logic [WD_W-1:0]          wd_val;
  logic [DAY_W-1:0]         dim_mm;

  function automatic logic valid_date(input logic [DAY_W-1:0]  d,
                                      input logic [MON_W-1:0]  m,
                                      input logic [YEAR_W-1:0] y);
    return (int'(y) >= BASE_YEAR) && (int'(y) <= YEAR_CAP) &&
           (m >= MON_W'(1)) && (m <= MON_W'(12)) && (d >= DAY_W'(1)) &&
           (d <= dcu_pkg::days_in_month(m, YP_W'(y)));
  endfunction

  dcu_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  dcu_dby #(
    .BASE_YEAR (BASE_YEAR)
  ) u_dby (
    .clk_i  (clk_i),
    .year_i (year_sel),
    .dby_o  (dby_q)
  );

  assign req_take = req_i.valid && req_ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign valid_a = valid_date(da_q, ma_q, ya_q);
  assign valid_b = valid_date(db_q, mb_q, yb_q);
  assign k_a = 10'(dcu_pkg::days_before_month(ma_q, YP_W'(ya_q))) + 10'(da_q) - 10'd1;
  assign k_b = 10'(dcu_pkg::days_before_month(mb_q, YP_W'(yb_q))) + 10'(db_q) - 10'd1;
  assign dim_mm = dcu_pkg::days_in_month(mm_q, yy_q);

  // year estimate: base year plus floor(n / 366), never above the true year
  assign est_prod = EST_PW'(n_q[REL_W-1:0]) * EST_PW'(EST_K);
  assign est_year = YP_W'(BASE_YEAR) + YP_W'(est_prod >> EST_SH);

  // weekday from the day count mod 7
  assign wd_sel  = ((st_q == dcu_pkg::ST_OK) && (op_q == dcu_pkg::OP_SHIFT)) ? n_q : acc_a_q;
  assign m7_prod = M7_PW'(wd_sel[REL_W-1:0]) * M7_PW'(M7_K);
  assign m7_q    = REL_W'(m7_prod >> M7_SH);
  assign m7_rem  = wd_sel[REL_W-1:0] - REL_W'(m7_q * REL_W'(7));
  assign wd_sum  = 4'(m7_rem[2:0]) + 4'(WD_OFF);
  assign wd_val  = (wd_sum >= 4'd7) ? WD_W'(wd_sum - 4'd7) + WD_W'(1) : WD_W'(wd_sum) + WD_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcu_pkg::S_IDLE: begin
        if (req_take) begin
          state_d = dcu_pkg::S_CHECK;
        end
      end
      dcu_pkg::S_CHECK: begin
        if (!valid_a || ((op_q == dcu_pkg::OP_DIST) && !valid_b)) begin
          state_d = dcu_pkg::S_PUT;
        end else begin
          state_d = dcu_pkg::S_OA;
        end
      end
      dcu_pkg::S_OA: begin
        state_d = (op_q == dcu_pkg::OP_DIST) ? dcu_pkg::S_OB : dcu_pkg::S_ADD;
      end
      dcu_pkg::S_OB:   state_d = dcu_pkg::S_DIFF;
      dcu_pkg::S_DIFF: state_d = (alu_sum < 0) ? dcu_pkg::S_ABS : dcu_pkg::S_WD;
      dcu_pkg::S_ABS:  state_d = dcu_pkg::S_WD;
      dcu_pkg::S_ADD:  state_d = dcu_pkg::S_RANGE;
      dcu_pkg::S_RANGE: begin
        if ((n_q < 0) || (n_q >= ORD_W'(LIMIT_REL))) begin
          state_d = dcu_pkg::S_WD;
        end else begin
          state_d = dcu_pkg::S_EST;
        end
      end
      dcu_pkg::S_EST:  state_d = dcu_pkg::S_YLO;
      dcu_pkg::S_YLO:  state_d = dcu_pkg::S_YSEL;
      dcu_pkg::S_YSEL: state_d = dcu_pkg::S_YCMP;
      dcu_pkg::S_YCMP: state_d = (alu_sum >= 0) ? dcu_pkg::S_YSEL : dcu_pkg::S_REST;
      dcu_pkg::S_REST: state_d = dcu_pkg::S_MON;
      dcu_pkg::S_MON: begin
        if (!((mm_q < MON_W'(12)) && (alu_sum >= 0))) begin
          state_d = dcu_pkg::S_WD;
        end
      end
      dcu_pkg::S_WD:   state_d = dcu_pkg::S_PUT;
      dcu_pkg::S_PUT: begin
        if (out_free) begin
          state_d = dcu_pkg::S_IDLE;
        end
      end
      default:         state_d = dcu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    year_sel    = YP_W'(ya_q);
    case (state_q)
      dcu_pkg::S_IDLE:  req_ready = 1'b1;
      dcu_pkg::S_CHECK: year_sel = YP_W'(ya_q);
      dcu_pkg::S_OA: begin
        alu_req.a = ORD_W'(dby_q);
        alu_req.b = ORD_W'(k_a);
        year_sel  = YP_W'(yb_q);
      end
      dcu_pkg::S_OB: begin
        alu_req.a = ORD_W'(dby_q);
        alu_req.b = ORD_W'(k_b);
      end
      dcu_pkg::S_DIFF: begin
        alu_req.a   = acc_a_q;
        alu_req.b   = acc_b_q;
        alu_req.sub = 1'b1;
      end
      dcu_pkg::S_ABS: begin
        alu_req.a   = acc_b_q;
        alu_req.b   = acc_a_q;
        alu_req.sub = 1'b1;
      end
      dcu_pkg::S_ADD: begin
        alu_req.a = acc_a_q;
        alu_req.b = ORD_W'(off_q);
      end
      dcu_pkg::S_YLO:  year_sel = yy_q;
      dcu_pkg::S_YSEL: year_sel = yy_q + YP_W'(1);
      dcu_pkg::S_YCMP: begin
        alu_req.a   = n_q;
        alu_req.b   = ORD_W'(dby_q);
        alu_req.sub = 1'b1;
        year_sel    = yy_q + YP_W'(1);
      end
      dcu_pkg::S_REST: begin
        alu_req.a   = n_q;
        alu_req.b   = ORD_W'(lo_q);
        alu_req.sub = 1'b1;
      end
      dcu_pkg::S_MON: begin
        alu_req.a   = ORD_W'(rest_q);
        alu_req.b   = ORD_W'(dim_mm);
        alu_req.sub = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == dcu_pkg::S_PUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dcu_pkg::S_IDLE: begin
        if (req_take) begin
          op_q   <= dcu_pkg::opcode_e'(req_i.opcode);
          da_q   <= req_i.day_a;
          ma_q   <= req_i.month_a;
          ya_q   <= req_i.year_a;
          off_q  <= req_i.offset;
          db_q   <= req_i.day_b;
          mb_q   <= req_i.month_b;
          yb_q   <= req_i.year_b;
          st_q   <= dcu_pkg::ST_OK;
          dist_q <= '0;
          wd_q   <= '0;
        end
      end
      dcu_pkg::S_CHECK: begin
        rd_q <= da_q;
        rm_q <= ma_q;
        ry_q <= ya_q;
        if (!valid_a || ((op_q == dcu_pkg::OP_DIST) && !valid_b)) begin
          st_q <= dcu_pkg::ST_INVALID;
        end
      end
      dcu_pkg::S_OA: acc_a_q <= alu_sum;
      dcu_pkg::S_OB: acc_b_q <= alu_sum;
      dcu_pkg::S_DIFF, dcu_pkg::S_ABS: begin
        if (alu_sum > ORD_W'(DIST_MAX)) begin
          dist_q <= '1;
        end else begin
          dist_q <= DIST_W'(alu_sum);
        end
      end
      dcu_pkg::S_ADD: n_q <= alu_sum;
      dcu_pkg::S_RANGE: begin
        if (n_q < 0) begin
          st_q <= dcu_pkg::ST_BEFORE;
        end else if (n_q >= ORD_W'(LIMIT_REL)) begin
          st_q <= dcu_pkg::ST_BEYOND;
        end
      end
      dcu_pkg::S_EST:  yy_q <= est_year;
      dcu_pkg::S_YSEL: lo_q <= dby_q;
      dcu_pkg::S_YCMP: begin
        if (alu_sum >= 0) begin
          yy_q <= yy_q + YP_W'(1);
        end
      end
      dcu_pkg::S_REST: begin
        rest_q <= 9'(alu_sum);
        mm_q   <= MON_W'(1);
      end
      dcu_pkg::S_MON: begin
        if ((mm_q < MON_W'(12)) && (alu_sum >= 0)) begin
          rest_q <= 9'(alu_sum);
          mm_q   <= mm_q + MON_W'(1);
        end else begin
          rd_q <= DAY_W'(rest_q) + DAY_W'(1);
          rm_q <= mm_q;
          ry_q <= yy_q[YEAR_W-1:0];
        end
      end
      dcu_pkg::S_WD: wd_q <= wd_val;
      dcu_pkg::S_PUT: begin
        if (out_free) begin
          out_day_q   <= rd_q;
          out_month_q <= rm_q;
          out_year_q  <= ry_q;
          out_dist_q  <= dist_q;
          out_wd_q    <= wd_q;
          out_st_q    <= st_q;
        end
      end
      default: begin
        lo_q <= lo_q;
      end
    endcase
  end

  assign req_i.ready     = req_ready;
  assign res_o.valid     = out_valid_q;
  assign res_o.res_day   = out_day_q;
  assign res_o.res_month = out_month_q;
  assign res_o.res_year  = out_year_q;
  assign res_o.distance  = out_dist_q;
  assign res_o.weekday   = out_wd_q;
  assign res_o.status    = out_st_q;

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> !req_i.ready)
    else $error("request taken while a previous one is in progress");

  a_invalid_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == dcu_pkg::ST_INVALID) |-> (res_o.weekday == '0))
    else $error("invalid date result carries a weekday");

  a_error_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != dcu_pkg::ST_OK) |-> (res_o.distance == '0))
    else $error("failed request carries a distance");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == dcu_pkg::ST_OK) |->
      (res_o.weekday >= WD_W'(1)) && (res_o.weekday <= WD_W'(7)) &&
      (res_o.res_month >= MON_W'(1)) && (res_o.res_month <= MON_W'(12)) &&
      (res_o.res_day >= DAY_W'(1)))
    else $error("good result with date or weekday out of range");

  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcu_pkg::S_MON) |-> (mm_q >= MON_W'(1)) && (mm_q <= MON_W'(12)))
    else $error("month walk left january to december");
`endif

endmodule

[sim/dcu_checker.sv]
module dcu_checker
  import dcu_pkg::*;
#(
  parameter int BASE_YEAR = BASE_YEAR_DEF,
  parameter int MAX_YEAR  = MAX_YEAR_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dcu_req_if   req_i,
  dcu_res_if   res_i,
  output int   err_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ANCHOR_YEAR = 1800;
  localparam longint YEAR_CAP    = (MAX_YEAR < 4095) ? MAX_YEAR : 4095;
  localparam longint DIST_MAX    = (longint'(1) << DIST_W) - 1;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [DIST_W-1:0] distance;
    logic [WD_W-1:0]   wday;
    status_e           status;
  } date_result_t;

  date_result_t expected_q[$];
  int           mismatches = 0;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint m, longint y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days before 1 january of year y
  function automatic longint days_to_year(longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint day_number(longint d, longint m, longint y);
    longint n;
    n = days_to_year(y);
    for (longint k = 1; k < m; k++) begin
      n += month_days(k, y);
    end
    return n + d - 1;
  endfunction

  function automatic bit date_ok(longint d, longint m, longint y);
    if (y < BASE_YEAR || y > YEAR_CAP || m < 1 || m > 12 || d < 1) begin
      return 1'b0;
    end
    return d <= month_days(m, y);
  endfunction

  // 1 monday .. 7 sunday, the anchor day being a wednesday
  function automatic logic [WD_W-1:0] weekday_of(longint n);
    longint x;
    longint w;
    x = n - day_number(1, 1, ANCHOR_YEAR);
    w = ((x % 7) + 7) % 7;
    return WD_W'((w + 2) % 7 + 1);
  endfunction

  function automatic date_result_t predict_date(logic op, longint da, longint ma, longint ya,
                                                longint off, longint db, longint mb,
                                                longint yb);
    date_result_t r;
    longint       oa;
    longint       ob;
    longint       n;
    longint       yy;
    longint       mm;
    longint       rest;
    longint       diff;
    r.day      = DAY_W'(da);
    r.month    = MON_W'(ma);
    r.year     = YEAR_W'(ya);
    r.distance = '0;
    r.wday     = '0;
    r.status   = ST_OK;
    if (!date_ok(da, ma, ya) || (op == OP_DIST && !date_ok(db, mb, yb))) begin
      r.status = ST_INVALID;
    end else begin
      oa     = day_number(da, ma, ya);
      r.wday = weekday_of(oa);
      if (op == OP_SHIFT) begin
        n = oa + off;
        if (n < days_to_year(BASE_YEAR)) begin
          r.status = ST_BEFORE;
        end else if (n >= days_to_year(YEAR_CAP + 1)) begin
          r.status = ST_BEYOND;
        end else begin
          yy = BASE_YEAR + (n - days_to_year(BASE_YEAR)) / 366;
          while (days_to_year(yy + 1) <= n) begin
            yy++;
          end
          rest = n - days_to_year(yy);
          mm   = 1;
          while (mm < 12 && rest >= month_days(mm, yy)) begin
            rest -= month_days(mm, yy);
            mm++;
          end
          r.day   = DAY_W'(rest + 1);
          r.month = MON_W'(mm);
          r.year  = YEAR_W'(yy);
          r.wday  = weekday_of(n);
        end
      end else begin
        ob         = day_number(db, mb, yb);
        diff       = (oa > ob) ? oa - ob : ob - oa;
        r.distance = DIST_W'((diff > DIST_MAX) ? DIST_MAX : diff);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    date_result_t e;
    if (rst_ni) begin
      // result side first: a request taken at this edge cannot be answered at it
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          e = expected_q.pop_front();
          if (res_i.res_day !== e.day) begin
            $error("res_day: expected %0d, got %0d", e.day, res_i.res_day);
            mismatches++;
          end
          if (res_i.res_month !== e.month) begin
            $error("res_month: expected %0d, got %0d", e.month, res_i.res_month);
            mismatches++;
          end
          if (res_i.res_year !== e.year) begin
            $error("res_year: expected %0d, got %0d", e.year, res_i.res_year);
            mismatches++;
          end
          if (res_i.distance !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, res_i.distance);
            mismatches++;
          end
          if (res_i.weekday !== e.wday) begin
            $error("weekday: expected %0d, got %0d", e.wday, res_i.weekday);
            mismatches++;
          end
          if (res_i.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, res_i.status);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(predict_date(req_i.opcode, req_i.day_a, req_i.month_a,
                                          req_i.year_a, req_i.offset, req_i.day_b,
                                          req_i.month_b, req_i.year_b));
      end
    end
    err_cnt_o <= mismatches;
    pending_o <= expected_q.size();
  end

endmodule

[sim/tb_top.sv]
module tb_top
  import dcu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 800;
  localparam int YEAR_TOP    = (1 << YEAR_W) - 1;

  typedef struct {
    opcode_e                  op;
    logic [DAY_W-1:0]         day_a;
    logic [MON_W-1:0]         month_a;
    logic [YEAR_W-1:0]        year_a;
    logic signed [OFF_W-1:0]  offset;
    logic [DAY_W-1:0]         day_b;
    logic [MON_W-1:0]         month_b;
    logic [YEAR_W-1:0]        year_b;
  } date_req_t;

  logic clk = 1'b0;
  logic rst_n;
  int   err_cnt;
  int   pending;
  int   hold_req = 0;
  int   cycle_cnt = 0;
  int   burst_left = 0;

  dcu_req_if req_ch ();
  dcu_res_if res_ch ();

  calendar_date_arithmetic_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  dcu_checker chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_ch),
    .res_i     (res_ch),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic date_req_t make_req(opcode_e op, int da, int ma, int ya, int off,
                                         int db, int mb, int yb);
    date_req_t r;
    r.op      = op;
    r.day_a   = DAY_W'(da);
    r.month_a = MON_W'(ma);
    r.year_a  = YEAR_W'(ya);
    r.offset  = OFF_W'(off);
    r.day_b   = DAY_W'(db);
    r.month_b = MON_W'(mb);
    r.year_b  = YEAR_W'(yb);
    return r;
  endfunction

  function automatic void random_date(output logic [DAY_W-1:0] d,
                                      output logic [MON_W-1:0] m,
                                      output logic [YEAR_W-1:0] y);
    case ($urandom_range(0, 9))
      0:       y = YEAR_W'($urandom_range(BASE_YEAR_DEF, BASE_YEAR_DEF + 2));
      1:       y = YEAR_W'($urandom_range(YEAR_TOP - 2, YEAR_TOP));
      default: y = YEAR_W'($urandom_range(BASE_YEAR_DEF, YEAR_TOP));
    endcase
    m = MON_W'($urandom_range(1, 12));
    d = ($urandom_range(0, 6) == 0) ? DAY_W'($urandom_range(29, 31))
                                    : DAY_W'($urandom_range(1, 28));
  endfunction

  function automatic date_req_t random_request();
    date_req_t r;
    r.op = opcode_e'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      // raw noise over the whole field ranges
      r.day_a   = DAY_W'($urandom);
      r.month_a = MON_W'($urandom);
      r.year_a  = YEAR_W'($urandom);
      r.offset  = OFF_W'($urandom);
      r.day_b   = DAY_W'($urandom);
      r.month_b = MON_W'($urandom);
      r.year_b  = YEAR_W'($urandom);
    end else begin
      random_date(r.day_a, r.month_a, r.year_a);
      random_date(r.day_b, r.month_b, r.year_b);
      case ($urandom_range(0, 3))
        0:       r.offset = OFF_W'(int'($urandom_range(0, 80)) - 40);
        1:       r.offset = OFF_W'(int'($urandom_range(0, 1600)) - 800);
        2:       r.offset = OFF_W'(int'($urandom_range(0, 400000)) - 200000);
        default: r.offset = OFF_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic push_request(input date_req_t r);
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= r.op;
    req_ch.day_a   <= r.day_a;
    req_ch.month_a <= r.month_a;
    req_ch.year_a  <= r.year_a;
    req_ch.offset  <= r.offset;
    req_ch.day_b   <= r.day_b;
    req_ch.month_b <= r.month_b;
    req_ch.year_b  <= r.year_b;
    do begin
      @(negedge clk);
    end while (!req_ch.ready);
    @(posedge clk);
  endtask

  // bursts of back-to-back requests separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // result side: stall pattern of its own plus one long hold-off on request
  initial begin
    int mode;
    int stretch;
    int hold_ack;
    hold_ack = 0;
    res_ch.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(5, 80);
      mode    = $urandom_range(0, 2);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req != hold_ack) begin
          res_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_ack = hold_req;
        end else begin
          case (mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            default: res_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    date_req_t directed_q[$];
    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.opcode  <= OP_SHIFT;
    req_ch.day_a   <= '0;
    req_ch.month_a <= '0;
    req_ch.year_a  <= '0;
    req_ch.offset  <= '0;
    req_ch.day_b   <= '0;
    req_ch.month_b <= '0;
    req_ch.year_b  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // range edges, leap rules and invalid dates, for shifts and distances
    directed_q.push_back(make_req(OP_SHIFT, 1, 1, 1800, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 1, 1800, -1, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 31, 12, 4095, 1, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 31, 12, 4095, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 28, 2, 2000, 1, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 28, 2, 1900, 1, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 29, 2, 2024, -366, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 3, 2100, -1, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 1, 1800, 1048575, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 31, 12, 4095, -1048576, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 1, 1800, 837000, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 29, 2, 1900, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 0, 1, 2000, 5, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 31, 4, 2000, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 0, 2000, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 1, 13, 2000, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 31, 15, 4095, -1, 31, 15, 4095));
    directed_q.push_back(make_req(OP_SHIFT, 31, 12, 1799, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_SHIFT, 10, 10, 2010, 100, 31, 15, 4095));
    directed_q.push_back(make_req(OP_DIST, 1, 1, 1800, 0, 31, 12, 4095));
    directed_q.push_back(make_req(OP_DIST, 31, 12, 4095, 0, 1, 1, 1800));
    directed_q.push_back(make_req(OP_DIST, 15, 8, 1987, 0, 15, 8, 1987));
    directed_q.push_back(make_req(OP_DIST, 1, 1, 2000, 0, 30, 2, 2000));
    directed_q.push_back(make_req(OP_DIST, 0, 5, 2000, 0, 1, 1, 2000));
    directed_q.push_back(make_req(OP_DIST, 1, 1, 2001, -1, 1, 1, 2000));
    foreach (directed_q[i]) begin
      push_request(directed_q[i]);
      pace();
    end
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) begin
        hold_req <= hold_req + 1;
      end
      push_request(random_request());
      pace();
      if (i == 550) begin
        drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dcu_pkg.sv
rtl/dcu_if.sv
rtl/dcu_alu.sv
rtl/dcu_dby.sv
rtl/calendar_date_arithmetic_unit.sv
sim/dcu_checker.sv
sim/tb_top.sv
